### design/assert_macros.svh
// Assertion macros shared by the RTL modules of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/adlb_pkg.sv
// Shared types and constants of the decimal list to binary converter.
`timescale 1ns / 1ps

package adlb_pkg;

    localparam int COUNT_DIGITS_DEFAULT = 3;
    localparam logic [7:0] COMMA_CHAR = 8'd44;
    localparam logic [7:0] DIGIT_ZERO = 8'd48;
    localparam logic [7:0] DIGIT_NINE = 8'd57;
    localparam logic [15:0] VALUE_MAX = 16'hFFFF;
    localparam int BUF_DEPTH = 3;

    // One byte of a binary unit with its flags.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } res_t;

    // Result bytes of one input transaction: none or two.
    typedef struct packed {
        logic valid;
        res_t hi;
        res_t lo;
    } push_t;

endpackage

### design/adlb_parser.sv
// Text unit parser: holds the parse state and forms the result bytes of each transaction.
`timescale 1ns / 1ps

module adlb_parser #(
    parameter int COUNT_DIGITS = adlb_pkg::COUNT_DIGITS_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    input  logic           end_of_data,
    output adlb_pkg::push_t push
);
    import adlb_pkg::*;
    `include "assert_macros.svh"

    localparam int HdsW = $clog2(COUNT_DIGITS + 1);

    typedef enum logic [2:0] {
        PH_TYPE = 3'b001,
        PH_HDR  = 3'b010,
        PH_NUM  = 3'b100
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [HdsW-1:0] hds_reg, hds_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic [7:0]      nd_reg, nd_next;
    logic [15:0]     acc_reg, acc_next;
    logic            hasd_reg, hasd_next;
    logic            err_reg, err_next;

    logic            is_dig;
    logic [3:0]      dval;
    logic [HdsW:0]   hds_inc;
    logic [7:0]      cnt_acc;
    logic [19:0]     acc_x10;
    logic [7:0]      nd_inc;

    assign is_dig  = (in_byte >= DIGIT_ZERO) && (in_byte <= DIGIT_NINE);
    assign dval    = is_dig ? in_byte[3:0] : 4'd0;
    assign hds_inc = {1'b0, hds_reg} + (HdsW + 1)'(1);
    assign cnt_acc = {cnt_reg[4:0], 3'b000} + {cnt_reg[6:0], 1'b0} + {4'b0000, dval};
    assign acc_x10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {16'd0, dval};
    assign nd_inc  = nd_reg + 8'd1;

    always_comb begin
        phase_next = phase_reg;
        hds_next   = hds_reg;
        cnt_next   = cnt_reg;
        nd_next    = nd_reg;
        acc_next   = acc_reg;
        hasd_next  = hasd_reg;
        err_next   = err_reg;
        push       = '0;

        unique case (phase_reg)
            PH_HDR: begin
                err_next = err_reg | ~is_dig;
                cnt_next = cnt_acc;
                if (hds_inc >= (HdsW + 1)'(COUNT_DIGITS)) begin
                    hds_next       = '0;
                    push.valid     = 1'b1;
                    push.hi.data   = 8'd0;
                    push.lo.data   = cnt_acc;
                    push.hi.err    = err_next;
                    push.lo.err    = err_next;
                    if (cnt_acc == 8'd0) begin
                        push.lo.last = 1'b1;
                        phase_next   = PH_TYPE;
                    end else begin
                        phase_next   = PH_NUM;
                    end
                end else begin
                    hds_next = hds_inc[HdsW-1:0];
                end
            end
            PH_NUM: begin
                if (in_byte == COMMA_CHAR) begin
                    push.valid   = 1'b1;
                    push.hi.data = acc_reg[15:8];
                    push.lo.data = acc_reg[7:0];
                    push.hi.err  = err_reg;
                    push.lo.err  = err_reg;
                    acc_next     = '0;
                    hasd_next    = 1'b0;
                    nd_next      = nd_inc;
                    if (nd_inc == cnt_reg) begin
                        push.lo.last = 1'b1;
                        phase_next   = PH_TYPE;
                    end
                end else if (in_byte <= 8'd1) begin
                    // The byte closes this unit and is the next unit's type byte.
                    push.valid   = 1'b1;
                    push.hi.data = acc_reg[15:8];
                    push.lo.data = acc_reg[7:0];
                    push.hi.err  = err_reg;
                    push.lo.err  = err_reg;
                    push.lo.last = 1'b1;
                    err_next     = 1'b0;
                    cnt_next     = '0;
                    nd_next      = '0;
                    acc_next     = '0;
                    hasd_next    = 1'b0;
                    hds_next     = '0;
                    phase_next   = PH_HDR;
                end else if (is_dig) begin
                    hasd_next = 1'b1;
                    if (|acc_x10[19:16]) begin
                        acc_next = VALUE_MAX;
                        err_next = 1'b1;
                    end else begin
                        acc_next = acc_x10[15:0];
                    end
                end else begin
                    err_next = 1'b1;
                end
            end
            default: begin
                err_next   = 1'b0;
                cnt_next   = '0;
                nd_next    = '0;
                acc_next   = '0;
                hasd_next  = 1'b0;
                hds_next   = '0;
                phase_next = PH_HDR;
            end
        endcase

        if (end_of_data) begin
            // A pending number is flushed; otherwise the last byte sent here closes the unit.
            if (phase_next == PH_NUM) begin
                if (hasd_next) begin
                    push.valid   = 1'b1;
                    push.hi.data = acc_next[15:8];
                    push.lo.data = acc_next[7:0];
                    push.hi.err  = err_next;
                    push.lo.err  = err_next;
                end
                push.lo.last = push.valid;
            end
            phase_next = PH_TYPE;
            hds_next   = '0;
            acc_next   = '0;
            hasd_next  = 1'b0;
        end

        if (!accept) begin
            push.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            hds_reg   <= '0;
            cnt_reg   <= '0;
            nd_reg    <= '0;
            acc_reg   <= '0;
            hasd_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            hds_reg   <= hds_next;
            cnt_reg   <= cnt_next;
            nd_reg    <= nd_next;
            acc_reg   <= acc_next;
            hasd_reg  <= hasd_next;
            err_reg   <= err_next;
        end
    end

    `ASSERT_IMPLY(a_no_emit_on_type, accept && (phase_reg == PH_TYPE), !push.valid,
        "result bytes produced for a type byte")
    `ASSERT_ALWAYS(a_hds_range, hds_reg < HdsW'(COUNT_DIGITS),
        "header digit counter past the count width")
    `ASSERT_NEXT(a_eod_resets, accept && end_of_data,
        (phase_reg == PH_TYPE) && !hasd_reg && (acc_reg == 16'd0),
        "end of data did not return the parser to the type byte")

endmodule

### design/adlb_out_buf.sv
// Three-entry result queue that takes two bytes at once and sends one per cycle while the receiver is ready.
`timescale 1ns / 1ps

module adlb_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  adlb_pkg::push_t push,
    output logic            room,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);
    import adlb_pkg::*;
    `include "assert_macros.svh"

    res_t       slot_reg [BUF_DEPTH];
    res_t       slot_next [BUF_DEPTH];
    logic [1:0] count_reg, count_next;
    logic [1:0] base_cnt;
    logic       pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = slot_reg[0].data;
    assign m_tlast  = slot_reg[0].last;
    assign m_tuser  = slot_reg[0].err;
    // A pair of bytes always fits while at most one is queued.
    assign room     = (count_reg <= 2'd1);
    assign base_cnt = count_reg - {1'b0, pop};

    always_comb begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            slot_next[i] = slot_reg[i];
        end
        if (pop) begin
            for (int i = 0; i < BUF_DEPTH - 1; i++) begin
                slot_next[i] = slot_reg[i + 1];
            end
        end
        count_next = base_cnt;
        if (push.valid) begin
            if (base_cnt == 2'd0) begin
                slot_next[0] = push.hi;
                slot_next[1] = push.lo;
            end else begin
                slot_next[1] = push.hi;
                slot_next[2] = push.lo;
            end
            count_next = base_cnt + 2'd2;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_count_range, count_reg <= 2'(BUF_DEPTH), "result queue overfilled")
    `ASSERT_IMPLY(a_push_room, push.valid, room, "bytes pushed without room")
    `ASSERT_NEXT(a_pop_only, pop && !push.valid, count_reg == $past(count_reg) - 2'd1,
        "queue count wrong after a send")

endmodule

### design/ascii_decimal_list_to_binary_unit.sv
// Top level of the ASCII decimal list to binary unit converter.
// Result bytes of an accepted transaction are registered in the result queue before they are offered.
// Throughput: one input byte per cycle while the result queue holds at most one byte; a byte that
// completes a header or a number yields two bytes, and the three-entry result queue then holds off
// input until the receiver has taken a byte and at most one is left.
// Reset: synchronous, active low; expects a type byte and empties the result queue.
`timescale 1ns / 1ps

module ascii_decimal_list_to_binary_unit #(
    parameter int COUNT_DIGITS = adlb_pkg::COUNT_DIGITS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte [7:0]
    input  logic       s_tlast,   // end_of_data
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte [7:0]
    output logic       m_tlast,   // unit_done
    output logic       m_tuser    // format_error [0]
);
    import adlb_pkg::*;

    push_t push;
    logic  room;
    logic  accept;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    adlb_parser #(
        .COUNT_DIGITS (COUNT_DIGITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_byte     (s_tdata),
        .end_of_data (s_tlast),
        .push        (push)
    );

    adlb_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### test/tb.sv
// Self-checking testbench for the ASCII decimal list to binary unit converter.
`timescale 1ns / 1ps

module tb;
    import adlb_pkg::*;

    localparam int COUNT_DIGITS = COUNT_DIGITS_DEFAULT;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 150;

    typedef enum logic [1:0] {
        PARSE_TYPE,
        PARSE_COUNT,
        PARSE_NUMBERS
    } parse_state_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } text_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    ascii_decimal_list_to_binary_unit #(
        .COUNT_DIGITS(COUNT_DIGITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    text_byte_t   text_feed[$];
    res_t         binary_expect[$];
    idle_mode_t   idle_mode = IDLE_NONE;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;
    int           errors = 0;
    int           bytes_fed = 0;
    int           bytes_taken = 0;
    int           bytes_checked = 0;
    int           units_closed = 0;
    int           quiet_cycles = 0;

    // Converter state as the predictor tracks it.
    parse_state_t parse_st;
    logic [1:0]   digits_seen;
    logic [7:0]   unit_cnt;
    logic [7:0]   nums_done;
    logic [15:0]  value_acc;
    logic         has_digits;
    logic         unit_err;
    res_t         step_buf[2];
    int           step_len;
    res_t         want;

    task automatic emit_byte(input logic [7:0] b);
        step_buf[step_len] = '{data: b, last: 1'b0, err: unit_err};
        step_len++;
    endtask

    task automatic emit_value();
        emit_byte(value_acc[15:8]);
        emit_byte(value_acc[7:0]);
        value_acc = 16'd0;
        has_digits = 1'b0;
    endtask

    task automatic close_unit();
        if (step_len > 0) begin
            step_buf[step_len - 1].last = 1'b1;
        end
    endtask

    task automatic begin_unit();
        unit_err = 1'b0;
        unit_cnt = 8'd0;
        nums_done = 8'd0;
        value_acc = 16'd0;
        has_digits = 1'b0;
        digits_seen = 2'd0;
        parse_st = PARSE_COUNT;
    endtask

    // Works out the binary bytes caused by one text byte.
    task automatic convert_byte(input logic [7:0] b, input logic eod);
        logic [7:0]  d;
        logic [19:0] v;
        step_len = 0;
        case (parse_st)
            PARSE_COUNT: begin
                d = 8'd0;
                if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
                    d = b - DIGIT_ZERO;
                end else begin
                    unit_err = 1'b1;
                end
                unit_cnt = unit_cnt * 8'd10 + d;
                digits_seen = digits_seen + 2'd1;
                if (int'(digits_seen) >= COUNT_DIGITS) begin
                    digits_seen = 2'd0;
                    emit_byte(8'h00);
                    emit_byte(unit_cnt);
                    if (unit_cnt == 8'd0) begin
                        close_unit();
                        parse_st = PARSE_TYPE;
                    end else begin
                        parse_st = PARSE_NUMBERS;
                    end
                end
            end
            PARSE_NUMBERS: begin
                if (b == COMMA_CHAR) begin
                    emit_value();
                    nums_done = nums_done + 8'd1;
                    if (nums_done == unit_cnt) begin
                        close_unit();
                        parse_st = PARSE_TYPE;
                    end
                end else if (b <= 8'd1) begin
                    // The byte closes this unit and is the next unit's type byte.
                    emit_value();
                    close_unit();
                    begin_unit();
                end else if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
                    v = {4'd0, value_acc} * 20'd10 + {12'd0, b - DIGIT_ZERO};
                    if (v > {4'd0, VALUE_MAX}) begin
                        v = {4'd0, VALUE_MAX};
                        unit_err = 1'b1;
                    end
                    value_acc = v[15:0];
                    has_digits = 1'b1;
                end else begin
                    unit_err = 1'b1;
                end
            end
            default: begin
                begin_unit();
            end
        endcase
        if (eod) begin
            if (parse_st == PARSE_NUMBERS) begin
                if (has_digits) begin
                    emit_value();
                end
                close_unit();
            end
            parse_st = PARSE_TYPE;
            digits_seen = 2'd0;
            value_acc = 16'd0;
            has_digits = 1'b0;
        end
        for (int i = 0; i < step_len; i++) begin
            binary_expect.push_back(step_buf[i]);
        end
    endtask

    // Driver: presents queued text bytes and predicts each accepted one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            parse_st = PARSE_TYPE;
            digits_seen = 2'd0;
            unit_cnt = 8'd0;
            nums_done = 8'd0;
            value_acc = 16'd0;
            has_digits = 1'b0;
            unit_err = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                convert_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (text_feed.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= text_feed[0].data;
                    s_tlast <= text_feed[0].eod;
                    void'(text_feed.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result byte against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (binary_expect.size() == 0) begin
                    $error("unexpected result byte: out_byte %0h unit_done %0b format_error %0b",
                           m_tdata, m_tlast, m_tuser);
                    errors++;
                end else begin
                    want = binary_expect.pop_front();
                    bytes_checked++;
                    if (want.last) begin
                        units_closed++;
                    end
                    if (m_tdata !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("unit_done: expected %0b, got %0b", want.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== want.err) begin
                        $error("format_error: expected %0b, got %0b", want.err, m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Watchdog on cycles in which no transaction happens on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d result bytes still expected", binary_expect.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic feed_byte(input logic [7:0] b, input logic eod);
        text_feed.push_back('{data: b, eod: eod});
        bytes_fed++;
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(2, 255));
        if ((b >= DIGIT_ZERO && b <= DIGIT_NINE) || b == COMMA_CHAR) begin
            b = 8'h7F;
        end
        return b;
    endfunction

    task automatic feed_number(input bit eod_on_last);
        int    pick;
        int    val;
        string txt;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            txt = "";
        end else if (pick < 75) begin
            val = $urandom_range(0, 999);
            txt = $sformatf("%0d", val);
        end else if (pick < 90) begin
            val = $urandom_range(0, 65535);
            txt = $sformatf("%0d", val);
        end else begin
            case ($urandom_range(0, 3))
                0: txt = "65535";
                1: txt = "65536";
                2: txt = "99999";
                default: txt = "0655350";
            endcase
        end
        if ($urandom_range(0, 99) < 5) begin
            feed_byte(junk_byte(), eod_on_last && txt.len() == 0);
        end
        for (int j = 0; j < txt.len(); j++) begin
            feed_byte(txt[j], eod_on_last && j == txt.len() - 1);
        end
    endtask

    // Queues one mostly well-formed text unit; tells whether the next unit
    // already has its type byte because this one ended on byte 0 or 1.
    task automatic queue_unit(input bit type_done, output bit next_type_done);
        int         cnt_val;
        int         nnum;
        int         n_noise;
        int         digit;
        bit         cut_short;
        logic [7:0] b;
        next_type_done = 1'b0;
        if ($urandom_range(0, 99) < 8) begin
            n_noise = $urandom_range(1, 8);
            for (int i = 0; i < n_noise; i++) begin
                feed_byte(8'($urandom_range(0, 255)), i == n_noise - 1);
            end
            return;
        end
        if (!type_done) begin
            feed_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        cnt_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 6);
        begin
            int eff;
            eff = 0;
            for (int k = 0; k < COUNT_DIGITS; k++) begin
                digit = (k == 0) ? cnt_val / 100 : (k == 1) ? (cnt_val / 10) % 10 : cnt_val % 10;
                b = DIGIT_ZERO + 8'(digit);
                if ($urandom_range(0, 99) < 4) begin
                    b = junk_byte();
                    digit = 0;
                end
                eff = (eff * 10 + digit) & 255;
                if ($urandom_range(0, 99) < 3) begin
                    // Stream ends inside the count.
                    feed_byte(b, 1'b1);
                    return;
                end
                feed_byte(b, 1'b0);
            end
            cnt_val = eff;
        end
        if (cnt_val == 0) begin
            return;
        end
        cut_short = (cnt_val > 8) || ($urandom_range(0, 99) < 15);
        nnum = cnt_val;
        if (cut_short) begin
            nnum = (cnt_val > 8) ? $urandom_range(0, 8) : $urandom_range(0, cnt_val - 1);
        end
        for (int i = 0; i < nnum; i++) begin
            feed_number(1'b0);
            feed_byte(COMMA_CHAR, 1'b0);
        end
        if (cut_short) begin
            if ($urandom_range(0, 1) == 0) begin
                feed_number(1'b0);
                feed_byte(8'($urandom_range(0, 1)), 1'b0);
                next_type_done = 1'b1;
            end else begin
                n_noise = $urandom_range(0, 3);
                if (n_noise == 0) begin
                    feed_byte(8'h20, 1'b1);
                end
                for (int j = 0; j < n_noise; j++) begin
                    feed_byte(DIGIT_ZERO + 8'($urandom_range(0, 9)), j == n_noise - 1);
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (text_feed.size() != 0 || s_tvalid || binary_expect.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        bit chained;
        int phase_start;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero count on a type byte of 255.
        feed_byte(8'hFF, 1'b0);
        feed_byte("0", 1'b0);
        feed_byte("0", 1'b0);
        feed_byte("0", 1'b0);
        // Non-digit in the count, overflow, ignored non-digit, empty number,
        // then a byte of value 1 cuts the unit short and becomes the type byte.
        feed_byte(8'h41, 1'b0);
        feed_byte("9", 1'b0);
        feed_byte("x", 1'b0);
        feed_byte("9", 1'b0);
        feed_byte("7", 1'b0);
        feed_byte("0", 1'b0);
        feed_byte("0", 1'b0);
        feed_byte("0", 1'b0);
        feed_byte("0", 1'b0);
        feed_byte(COMMA_CHAR, 1'b0);
        feed_byte("*", 1'b0);
        feed_byte(COMMA_CHAR, 1'b0);
        feed_byte(8'h01, 1'b0);
        // Stream ends inside the count: nothing comes out.
        feed_byte("9", 1'b0);
        feed_byte("9", 1'b1);
        // Byte 0 as type, end of data flushes a pending number.
        feed_byte(8'h00, 1'b0);
        feed_byte("0", 1'b0);
        feed_byte("0", 1'b0);
        feed_byte("2", 1'b0);
        feed_byte("5", 1'b1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = idle_mode_t'(ph);
            case (idle_mode)
                IDLE_NONE: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                IDLE_SENDER: begin
                    sender_idle_pct = 80;
                    receiver_stall_pct = 0;
                end
                IDLE_RECEIVER: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 80;
                end
                default: begin
                    sender_idle_pct = 10;
                    receiver_stall_pct = 10;
                end
            endcase
            phase_start = bytes_fed;
            chained = 1'b0;
            while (bytes_fed - phase_start < ITEMS_PER_PHASE) begin
                queue_unit(chained, chained);
            end
            // A unit that ended on byte 0 or 1 still needs its count.
            if (chained) begin
                feed_byte("0", 1'b0);
                feed_byte("0", 1'b0);
                feed_byte("0", 1'b0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Fed %0d text bytes, %0d accepted; checked %0d binary bytes in %0d units.",
                 bytes_fed, bytes_taken, bytes_checked, units_closed);
        $display("Ran with no idling, sender gaps, receiver stalls and light mixed idling.");
        if (errors == 0 && binary_expect.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### ascii_decimal_list_to_binary_unit.f
+incdir+design
design/adlb_pkg.sv
design/adlb_parser.sv
design/adlb_out_buf.sv
design/ascii_decimal_list_to_binary_unit.sv
test/tb.sv
